[src/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[src/lsc_pkg.sv]
package lsc_pkg;

   localparam int COORD_W = 32;
   localparam int FRAC_W  = 16;
   localparam int NUM_EDGES = 4;
   // Exact differences need one extra bit; DIFF_W gives two.
   localparam int DIFF_W  = COORD_W + 2;
   // Parameter t is unsigned Q1.FRAC_W.
   localparam int T_W     = FRAC_W + 1;

   localparam logic [1:0] CSR_LEFT   = 2'd0;
   localparam logic [1:0] CSR_RIGHT  = 2'd1;
   localparam logic [1:0] CSR_BOTTOM = 2'd2;
   localparam logic [1:0] CSR_TOP    = 2'd3;
   localparam int CSR_IDX_W = 3;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic                      visible;
      logic signed [COORD_W-1:0] clipped_start_x;
      logic signed [COORD_W-1:0] clipped_start_y;
      logic signed [COORD_W-1:0] clipped_end_x;
      logic signed [COORD_W-1:0] clipped_end_y;
   } rsp_type;

   // Per-edge magnitude with the sign classification of its numerator.
   typedef struct packed {
      logic              par;     // p == 0
      logic              entering; // p < 0
      logic              neg;     // numerator below zero
      logic              over;    // numerator above magnitude
      logic              one;     // numerator equals magnitude
      logic [DIFF_W-1:0] mag;
   } edge_type;

   // What travels from one divider or edge cell to the next.
   typedef struct packed {
      logic                      valid;
      logic                      ok;
      logic [T_W-1:0]            t0;
      logic [T_W-1:0]            t1;
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic signed [DIFF_W-1:0]  dx;
      logic signed [DIFF_W-1:0]  dy;
      edge_type [NUM_EDGES-1:0]  edges;
      logic [NUM_EDGES-1:0][DIFF_W-1:0] rem;
      logic [NUM_EDGES-1:0][FRAC_W-1:0] quo;
   } link_type;

endpackage

[src/lsc_div_cell.sv]
// One restoring step on every edge ratio at once.
module lsc_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  lsc_pkg::link_type link_in,
   output lsc_pkg::link_type link_out
);
   import lsc_pkg::*;

   link_type link_ff, link_in_c;
   logic [DIFF_W:0] shifted;

   always_comb begin
      link_in_c = link_in;
      shifted   = '0;
      for (int e = 0; e < NUM_EDGES; e++) begin
         shifted = {link_in.rem[e], 1'b0};
         if (shifted >= {1'b0, link_in.edges[e].mag}) begin
            link_in_c.rem[e] = DIFF_W'(shifted - {1'b0, link_in.edges[e].mag});
            link_in_c.quo[e] = {link_in.quo[e][FRAC_W-2:0], 1'b1};
         end else begin
            link_in_c.rem[e] = shifted[DIFF_W-1:0];
            link_in_c.quo[e] = {link_in.quo[e][FRAC_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
      end else begin
         link_ff <= link_in_c;
      end
   end

   assign link_out = link_ff;
endmodule

[src/lsc_edge_cell.sv]
// Tightens t0/t1 against edge EDGE, or clears ok to reject the segment; the edges follow in order along the chain.
module lsc_edge_cell #(
   parameter int EDGE = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  lsc_pkg::link_type link_in,
   output lsc_pkg::link_type link_out
);
   import lsc_pkg::*;

   link_type link_ff, link_in_c;
   edge_type ed;
   logic [T_W-1:0] r;
   logic           r_neg, r_over;

   always_comb begin
      link_in_c = link_in;
      ed     = link_in.edges[EDGE];
      r_neg  = ed.neg;
      r_over = ed.over;
      r      = ed.one ? T_W'(1) << FRAC_W : {1'b0, link_in.quo[EDGE]};
      if (link_in.ok) begin
         if (ed.par) begin
            if (ed.neg) begin
               link_in_c.ok = 1'b0;
            end
         end else if (ed.entering) begin
            if (r_over) begin
               link_in_c.ok = 1'b0;
            end else if (!r_neg) begin
               if (r > link_in.t1) begin
                  link_in_c.ok = 1'b0;
               end else if (r > link_in.t0) begin
                  link_in_c.t0 = r;
               end
            end
         end else begin
            if (r_neg) begin
               link_in_c.ok = 1'b0;
            end else if (!r_over) begin
               if (r < link_in.t0) begin
                  link_in_c.ok = 1'b0;
               end else if (r < link_in.t1) begin
                  link_in_c.t1 = r;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
      end else begin
         link_ff <= link_in_c;
      end
   end

   assign link_out = link_ff;
endmodule

[src/lsc_point_unit.sv]
// Computes the clipped points: multiply stage, then add and clamp stage.
module lsc_point_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  lsc_pkg::link_type                link_in,
   input  logic signed [lsc_pkg::COORD_W-1:0] win_left,
   input  logic signed [lsc_pkg::COORD_W-1:0] win_right,
   input  logic signed [lsc_pkg::COORD_W-1:0] win_bottom,
   input  logic signed [lsc_pkg::COORD_W-1:0] win_top,
   output logic                             rsp_valid,
   output lsc_pkg::rsp_type                 rsp_data
);
   import lsc_pkg::*;

   localparam int MAG_W = DIFF_W;
   localparam int HI_W  = MAG_W - FRAC_W;
   localparam int PH_W  = HI_W + T_W;
   localparam int PL_W  = FRAC_W + T_W;

   // Stage 1: partial products for the four offsets.
   logic                    v1_ff, ok1_ff;
   logic signed [COORD_W-1:0] x0_1_ff, y0_1_ff;
   logic [3:0]              neg1_ff;
   logic [3:0][PH_W-1:0]    ph_ff;
   logic [3:0][PL_W-1:0]    pl_ff;

   logic [3:0][MAG_W-1:0] mag;
   logic [3:0][T_W-1:0]   tt;
   logic [3:0]            negd;

   always_comb begin
      negd[0] = link_in.dx[DIFF_W-1];
      negd[1] = link_in.dy[DIFF_W-1];
      negd[2] = link_in.dx[DIFF_W-1];
      negd[3] = link_in.dy[DIFF_W-1];
      mag[0] = negd[0] ? MAG_W'(-link_in.dx) : MAG_W'(link_in.dx);
      mag[1] = negd[1] ? MAG_W'(-link_in.dy) : MAG_W'(link_in.dy);
      mag[2] = mag[0];
      mag[3] = mag[1];
      tt[0] = link_in.t0;
      tt[1] = link_in.t0;
      tt[2] = link_in.t1;
      tt[3] = link_in.t1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= link_in.valid;
      end
      ok1_ff  <= link_in.ok;
      x0_1_ff <= link_in.x0;
      y0_1_ff <= link_in.y0;
      neg1_ff <= negd;
      for (int i = 0; i < 4; i++) begin
         ph_ff[i] <= PH_W'(tt[i] * mag[i][MAG_W-1:FRAC_W]);
         pl_ff[i] <= PL_W'(tt[i] * mag[i][FRAC_W-1:0]);
      end
   end

   // Stage 2: sum, sign, add to start and clamp.
   rsp_type rsp_ff, rsp_in;
   logic    v2_ff;
   logic signed [DIFF_W+1:0] off, pt;
   logic signed [DIFF_W+1:0] lo, hi;

   always_comb begin
      rsp_in = '0;
      off = '0;
      pt  = '0;
      lo  = '0;
      hi  = '0;
      if (ok1_ff) begin
         rsp_in.visible = 1'b1;
         for (int i = 0; i < 4; i++) begin
            off = (DIFF_W+2)'(ph_ff[i]) + (DIFF_W+2)'(pl_ff[i] >> FRAC_W);
            if (neg1_ff[i]) begin
               off = -off;
            end
            if (i == 0 || i == 2) begin
               pt = (DIFF_W+2)'(x0_1_ff) + off;
               lo = (DIFF_W+2)'(win_left);
               hi = (DIFF_W+2)'(win_right);
            end else begin
               pt = (DIFF_W+2)'(y0_1_ff) + off;
               lo = (DIFF_W+2)'(win_bottom);
               hi = (DIFF_W+2)'(win_top);
            end
            if (pt < lo) begin
               pt = lo;
            end
            if (pt > hi) begin
               pt = hi;
            end
            case (i)
               0: rsp_in.clipped_start_x = pt[COORD_W-1:0];
               1: rsp_in.clipped_start_y = pt[COORD_W-1:0];
               2: rsp_in.clipped_end_x   = pt[COORD_W-1:0];
               default: rsp_in.clipped_end_y = pt[COORD_W-1:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = v2_ff;
   assign rsp_data  = rsp_ff;
endmodule

[src/line_segment_window_clipper.sv]
// Liang-Barsky clipper of one segment against the window in registers 0..3
// (left, right, bottom, top). A transaction is taken at every clock edge where
// start is high and busy is low; busy is never raised, so one segment enters
// per cycle. Its result appears on rsp_data with rsp_valid high for exactly one
// cycle, after the segment has passed one setup stage, sixteen divider cells
// (one quotient bit each, all edge ratios in parallel), the edge cells for left,
// right, bottom and top, and two multiply and clamp stages. The receiver cannot
// stall the block. Window writes must only be made while no segment is in flight.
module line_segment_window_clipper (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  lsc_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   output lsc_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [lsc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [lsc_pkg::COORD_W-1:0]           csr_wdata
);
   import lsc_pkg::*;

   logic signed [COORD_W-1:0] left_ff, right_ff, bottom_ff, top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         right_ff  <= '0;
         bottom_ff <= '0;
         top_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            {1'b0, CSR_LEFT}:   left_ff   <= csr_wdata;
            {1'b0, CSR_RIGHT}:  right_ff  <= csr_wdata;
            {1'b0, CSR_BOTTOM}: bottom_ff <= csr_wdata;
            {1'b0, CSR_TOP}:    top_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // Setup stage: differences and per-edge classification.
   link_type setup_in, setup_ff;
   logic signed [DIFF_W-1:0] x0, y0, dx, dy;
   logic signed [DIFF_W-1:0] p [NUM_EDGES];
   logic signed [DIFF_W-1:0] q [NUM_EDGES];
   logic signed [DIFF_W-1:0] num, mg;

   always_comb begin
      x0 = DIFF_W'(req_data.start_x);
      y0 = DIFF_W'(req_data.start_y);
      dx = DIFF_W'(req_data.end_x) - x0;
      dy = DIFF_W'(req_data.end_y) - y0;
      p[0] = -dx; q[0] = x0 - DIFF_W'(left_ff);
      p[1] = dx;  q[1] = DIFF_W'(right_ff) - x0;
      p[2] = -dy; q[2] = y0 - DIFF_W'(bottom_ff);
      p[3] = dy;  q[3] = DIFF_W'(top_ff) - y0;
      setup_in = '0;
      setup_in.valid = start;
      setup_in.ok = 1'b1;
      setup_in.t0 = '0;
      setup_in.t1 = T_W'(1) << FRAC_W;
      setup_in.x0 = req_data.start_x;
      setup_in.y0 = req_data.start_y;
      setup_in.dx = dx;
      setup_in.dy = dy;
      num = '0;
      mg  = '0;
      for (int e = 0; e < NUM_EDGES; e++) begin
         mg  = p[e][DIFF_W-1] ? -p[e] : p[e];
         num = p[e][DIFF_W-1] ? -q[e] : q[e];
         setup_in.edges[e].par = (p[e] == '0);
         setup_in.edges[e].entering = p[e][DIFF_W-1];
         setup_in.edges[e].neg  = (p[e] == '0) ? q[e][DIFF_W-1] : num[DIFF_W-1];
         setup_in.edges[e].over = !num[DIFF_W-1] && (num > mg);
         setup_in.edges[e].one  = (num == mg);
         setup_in.edges[e].mag  = mg;
         // Only a proper fraction is divided; other cases bypass the quotient.
         setup_in.rem[e] = (!num[DIFF_W-1] && num < mg) ? num : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ff <= '0;
      end else begin
         setup_ff <= setup_in;
      end
   end

   link_type chain [FRAC_W+NUM_EDGES+1];
   assign chain[0] = setup_ff;

   for (genvar i = 0; i < FRAC_W; i++) begin : g_div
      lsc_div_cell u_div (
         .clock(clock), .reset(reset), .link_in(chain[i]), .link_out(chain[i+1])
      );
   end

   for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
      lsc_edge_cell #(.EDGE(e)) u_edge (
         .clock(clock), .reset(reset),
         .link_in(chain[FRAC_W+e]), .link_out(chain[FRAC_W+e+1])
      );
   end

   lsc_point_unit u_point (
      .clock(clock), .reset(reset), .link_in(chain[FRAC_W+NUM_EDGES]),
      .win_left(left_ff), .win_right(right_ff),
      .win_bottom(bottom_ff), .win_top(top_ff),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );
endmodule

[src/lsc_checker.sv]
`include "assert_macros.svh"

module lsc_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input lsc_pkg::rsp_type rsp_data
);
   import lsc_pkg::*;

   `ASSERT_IMPLIES(a_never_busy, clock, reset, 1'b1, !busy)
   `ASSERT_IMPLIES(a_reject_zero, clock, reset, rsp_valid && !rsp_data.visible, rsp_data.clipped_start_x == '0 && rsp_data.clipped_end_y == '0)
   `ASSERT_NEXT(a_no_early, clock, reset, $past(reset), !rsp_valid)
   `ASSERT_IMPLIES(a_latency, clock, reset, rsp_valid, $past(start, 23))
endmodule

bind line_segment_window_clipper lsc_checker u_lsc_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);

[verif/line_segment_window_clipper_test.sv]
`timescale 1ns / 1ps

module line_segment_window_clipper_test;
   import lsc_pkg::*;

   localparam int  ONE_FX        = 1 << FRAC_W;
   localparam int  DRAIN_CYCLES  = 40;
   localparam int  CYCLE_LIMIT   = 400000;
   localparam int  ITEMS_PER_WIN = 325;
   localparam int  NUM_WINDOWS   = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LAST  = 3'd7;

   typedef struct {
      req_type seg;
      bit      typed;
      rsp_type clipped;
   } seg_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COORD_W-1:0]   csr_wdata = '0;

   longint  win_left, win_right, win_bottom, win_top;
   rsp_type clip_queue[$];
   int      fail_count = 0;
   int      cycle_count = 0;
   int      idle_pct = 0;

   line_segment_window_clipper dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [COORD_W-1:0] fx(int n);
      return COORD_W'(n * ONE_FX);
   endfunction

   // floor(num * 2^FRAC_W / den) by restoring division; num < den.
   function automatic longint ratio_frac(longint num, longint den);
      longint quo;
      longint rem;
      quo = 0;
      rem = num;
      for (int i = 0; i < FRAC_W; i++) begin
         rem = rem << 1;
         quo = quo << 1;
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | 1;
         end
      end
      return quo;
   endfunction

   function automatic longint scale_by_t(longint t, longint d);
      longint mag;
      longint hi;
      longint lo;
      mag = (d < 0) ? -d : d;
      hi  = mag >>> FRAC_W;
      lo  = mag & ((64'sd1 <<< FRAC_W) - 1);
      hi  = t * hi + ((t * lo) >>> FRAC_W);
      return (d < 0) ? -hi : hi;
   endfunction

   function automatic longint clamp_to(longint v, longint lo, longint hi);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   function automatic rsp_type clip_segment(req_type seg);
      longint  x0, y0, dx, dy, p, q, mag, num, r, t0, t1;
      longint  pv[NUM_EDGES];
      longint  qv[NUM_EDGES];
      bit      ok;
      rsp_type res;
      x0 = longint'($signed(seg.start_x));
      y0 = longint'($signed(seg.start_y));
      dx = longint'($signed(seg.end_x)) - x0;
      dy = longint'($signed(seg.end_y)) - y0;
      pv[0] = -dx; qv[0] = x0 - win_left;
      pv[1] = dx;  qv[1] = win_right - x0;
      pv[2] = -dy; qv[2] = y0 - win_bottom;
      pv[3] = dy;  qv[3] = win_top - y0;
      t0 = 0;
      t1 = ONE_FX;
      ok = 1'b1;
      for (int e = 0; e < NUM_EDGES && ok; e++) begin
         p = pv[e];
         q = qv[e];
         if (p == 0) begin
            if (q < 0) ok = 1'b0;
            continue;
         end
         mag = (p < 0) ? -p : p;
         num = (p < 0) ? -q : q;
         if (num < 0) r = -1;
         else if (num > mag) r = ONE_FX + 1;
         else if (num == mag) r = ONE_FX;
         else r = ratio_frac(num, mag);
         if (p < 0) begin
            if (r > t1) ok = 1'b0;
            else if (r > t0) t0 = r;
         end else begin
            if (r < t0) ok = 1'b0;
            else if (r < t1) t1 = r;
         end
      end
      res = '0;
      if (ok) begin
         res.visible         = 1'b1;
         res.clipped_start_x = COORD_W'(clamp_to(x0 + scale_by_t(t0, dx), win_left, win_right));
         res.clipped_start_y = COORD_W'(clamp_to(y0 + scale_by_t(t0, dy), win_bottom, win_top));
         res.clipped_end_x   = COORD_W'(clamp_to(x0 + scale_by_t(t1, dx), win_left, win_right));
         res.clipped_end_y   = COORD_W'(clamp_to(y0 + scale_by_t(t1, dy), win_bottom, win_top));
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [COORD_W-1:0] got,
                                  logic [COORD_W-1:0] want);
      $display("MISMATCH %s: got %h, expected %h at cycle %0d", what, got, want,
               cycle_count);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (clip_queue.size() == 0) begin
            report_mismatch("unexpected result", rsp_data.clipped_start_x, '0);
         end else begin
            want = clip_queue.pop_front();
            if (rsp_data.visible !== want.visible)
               report_mismatch("visible", rsp_data.visible, want.visible);
            if (rsp_data.clipped_start_x !== want.clipped_start_x)
               report_mismatch("clipped_start_x", rsp_data.clipped_start_x,
                               want.clipped_start_x);
            if (rsp_data.clipped_start_y !== want.clipped_start_y)
               report_mismatch("clipped_start_y", rsp_data.clipped_start_y,
                               want.clipped_start_y);
            if (rsp_data.clipped_end_x !== want.clipped_end_x)
               report_mismatch("clipped_end_x", rsp_data.clipped_end_x,
                               want.clipped_end_x);
            if (rsp_data.clipped_end_y !== want.clipped_end_y)
               report_mismatch("clipped_end_y", rsp_data.clipped_end_y,
                               want.clipped_end_y);
         end
      end
   end

   // Offers one segment and holds it until a transaction takes place.
   task automatic send_segment(req_type seg, bit typed, rsp_type typed_result);
      rsp_type expected;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= seg;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      expected   = typed ? typed_result : clip_segment(seg);
      clip_queue = {clip_queue, expected};
   endtask

   // Lowers start and lets the pipeline empty before the window is touched.
   task automatic drain;
      @(negedge clock);
      start <= 1'b0;
      while (clip_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [COORD_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         {1'b0, CSR_LEFT}:   win_left   = longint'($signed(value));
         {1'b0, CSR_RIGHT}:  win_right  = longint'($signed(value));
         {1'b0, CSR_BOTTOM}: win_bottom = longint'($signed(value));
         {1'b0, CSR_TOP}:    win_top    = longint'($signed(value));
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_window(logic [COORD_W-1:0] l, logic [COORD_W-1:0] r,
                             logic [COORD_W-1:0] b, logic [COORD_W-1:0] t);
      write_reg({1'b0, CSR_LEFT}, l);
      write_reg({1'b0, CSR_RIGHT}, r);
      write_reg({1'b0, CSR_BOTTOM}, b);
      write_reg({1'b0, CSR_TOP}, t);
      // Indexes beyond the window registers must leave it untouched.
      write_reg(CSR_IDX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)), $urandom);
   endtask

   // A coordinate around the interval [a, b] with a margin on both sides.
   function automatic logic [COORD_W-1:0] coord_near(longint a, longint b);
      longint lo, span, margin;
      longint unsigned pick;
      lo     = (a < b) ? a : b;
      span   = (a < b) ? b - a : a - b;
      margin = span / 4 + 16 * ONE_FX;
      pick   = {$urandom, $urandom};
      return COORD_W'(lo - margin + longint'(pick % longint'(span + 2 * margin + 1)));
   endfunction

   function automatic logic [COORD_W-1:0] coord_extreme();
      case ($urandom_range(3))
         0: return {1'b1, {(COORD_W-1){1'b0}}};
         1: return {1'b0, {(COORD_W-1){1'b1}}};
         2: return '0;
         default: return '1;
      endcase
   endfunction

   function automatic req_type random_segment();
      req_type seg;
      int      mode;
      mode = $urandom_range(9);
      if (mode <= 5) begin
         seg.start_x = coord_near(win_left, win_right);
         seg.start_y = coord_near(win_bottom, win_top);
         seg.end_x   = coord_near(win_left, win_right);
         seg.end_y   = coord_near(win_bottom, win_top);
      end else if (mode <= 7) begin
         seg = {$urandom, $urandom, $urandom, $urandom};
      end else if (mode == 8) begin
         seg.start_x = ($urandom_range(1)) ? coord_extreme() : coord_near(win_left, win_right);
         seg.start_y = ($urandom_range(1)) ? coord_extreme() : coord_near(win_bottom, win_top);
         seg.end_x   = coord_extreme();
         seg.end_y   = coord_extreme();
      end else begin
         seg.start_x = coord_near(win_left, win_right);
         seg.start_y = coord_near(win_bottom, win_top);
         seg.end_x   = seg.start_x;
         seg.end_y   = seg.start_y;
      end
      return seg;
   endfunction

   function automatic seg_row_type make_row(int x0, int y0, int x1, int y1, bit typed,
                                            bit vis, int cx0, int cy0, int cx1, int cy1);
      seg_row_type row;
      row.seg             = '{fx(x0), fx(y0), fx(x1), fx(y1)};
      row.typed           = typed;
      row.clipped.visible = vis;
      row.clipped.clipped_start_x = fx(cx0);
      row.clipped.clipped_start_y = fx(cy0);
      row.clipped.clipped_end_x   = fx(cx1);
      row.clipped.clipped_end_y   = fx(cy1);
      return row;
   endfunction

   initial begin
      seg_row_type rows[$];
      seg_row_type row;
      logic [COORD_W-1:0] windows[NUM_WINDOWS][4];
      int idle_plan[NUM_WINDOWS];

      win_left = 0; win_right = 0; win_bottom = 0; win_top = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Window of zero size straight after reset: only the origin survives.
      send_segment('{fx(0), fx(0), fx(0), fx(0)}, 1'b1, '{1'b1, '0, '0, '0, '0});
      send_segment('{fx(1), fx(0), fx(2), fx(0)}, 1'b1, '0);
      drain();

      set_window(fx(-10), fx(10), fx(-5), fx(5));
      rows = {rows, make_row(-1, -1, 2, 3, 1, 1, -1, -1, 2, 3)};    // wholly inside
      rows = {rows, make_row(-20, -1, -20, 1, 1, 0, 0, 0, 0, 0)};   // parallel, left of window
      rows = {rows, make_row(0, 6, 3, 6, 1, 0, 0, 0, 0, 0)};        // parallel, above window
      rows = {rows, make_row(-20, 0, 20, 0, 1, 1, -10, 0, 10, 0)};  // crosses the left and right edges
      rows = {rows, make_row(20, 0, -20, 0, 0, 0, 0, 0, 0, 0)};     // same, reversed
      rows = {rows, make_row(3, 3, 3, 3, 1, 1, 3, 3, 3, 3)};        // single point inside
      rows = {rows, make_row(30, 0, 30, 0, 1, 0, 0, 0, 0, 0)};      // single point outside
      rows = {rows, make_row(-15, -8, 12, 9, 0, 0, 0, 0, 0, 0)};    // diagonal through
      rows = {rows, make_row(10, 0, 20, 0, 0, 0, 0, 0, 0, 0)};      // touches the right edge
      rows = {rows, make_row(-20, 8, -8, 20, 0, 0, 0, 0, 0, 0)};    // misses a corner
      rows = {rows, make_row(0, -30, 1, 30, 0, 0, 0, 0, 0, 0)};     // steep, crosses the bottom and top edges
      foreach (rows[i]) send_segment(rows[i].seg, rows[i].typed, rows[i].clipped);
      row.typed = 1'b0;
      row.seg = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff};
      send_segment(row.seg, 1'b0, '0);
      row.seg = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff};
      send_segment(row.seg, 1'b0, '0);
      send_segment('{'0, '1, '1, '0}, 1'b0, '0);
      send_segment('{'1, '1, '1, '1}, 1'b0, '0);
      drain();

      windows[0] = '{fx(-10), fx(10), fx(-5), fx(5)};
      windows[1] = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
      windows[2] = '{fx(5), fx(-5), fx(3), fx(-3)};    // inverted on both axes
      windows[3] = '{fx(2), fx(2), fx(-1), fx(-1)};    // collapsed to a point
      windows[4] = '{$urandom, $urandom, $urandom, $urandom};
      windows[5] = '{32'h8000_0000, fx(0), fx(-100), 32'h7fff_ffff};
      idle_plan  = '{13, 13, 53, 53, 0, 0};

      for (int w = 0; w < NUM_WINDOWS; w++) begin
         set_window(windows[w][0], windows[w][1], windows[w][2], windows[w][3]);
         idle_pct = idle_plan[w];
         for (int n = 0; n < ITEMS_PER_WIN; n++) begin
            // Bursts with no gaps at all now and then.
            if (idle_plan[w] != 0 && n % 100 == 50) idle_pct = 0;
            if (n % 100 == 75) idle_pct = idle_plan[w];
            send_segment(random_segment(), 1'b0, '0);
         end
         drain();
      end

      if (clip_queue.size() != 0) begin
         report_mismatch("results never arrived", COORD_W'(clip_queue.size()), '0);
      end
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/lsc_pkg.sv
src/lsc_div_cell.sv
src/lsc_edge_cell.sv
src/lsc_point_unit.sv
src/line_segment_window_clipper.sv
src/lsc_checker.sv
verif/line_segment_window_clipper_test.sv
